[sv/pool2d_pkg.sv]
`timescale 1ns / 1ps
package pool2d_pkg;

   // Window positions and register widths are fixed by the 1024 position limit.
   localparam int POS_W     = 10;
   localparam int SIZE_W    = 11;
   localparam int POS_LIMIT = 1024;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 11;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_MODE        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_HEIGHT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_WIDTH    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_HEIGHT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_WIDTH   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE_PAIR = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_PAIR    = 3'd7;

   localparam logic MODE_AVG = 1'b1;

endpackage

[sv/pool2d_ram.sv]
`timescale 1ns / 1ps
module pool2d_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/pool2d_max_avg_stream_top.sv]
`timescale 1ns / 1ps
// Streaming 2-D max / average pooling over one channel plane.
// The req channel carries one signed sample per word in raster order; the block
// keeps the last MAX_KERNEL rows in a line store (one synchronous RAM) and, on the
// sample that is the bottom-right pixel of one or more clipped windows, sends one
// rsp word per window, ordered by window row and then column, with run_last set
// on the last word caused by that sample. The csr channel writes the registers
// and is always ready; write it only while the block is idle.
// Steps per sample: an accept step, a search for the first window on each axis (a
// restoring divide by the stride, one divider per axis), a count of the windows,
// then per window: a setup step, one line store read per window pixel (up to 64),
// a drain step and a select step, a further restoring division in average mode,
// and a load of the output register. A sample that closes no window returns to
// idle after the count.
// The output register holds a word until rsp_ready; the next window waits only
// when it is ready to be loaded, and a new sample may be accepted while the
// last word still waits. Reset clears the position and rsp_valid, and sets the
// registers to defaults; the line store is not cleared and needs no clearing pass.
module pool2d_max_avg_stream_top #(
   parameter int MAX_WIDTH   = 1024,
   parameter int MAX_KERNEL  = 8,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pool2d_pkg::POS_W-1:0]        rsp_out_row,
   output logic [pool2d_pkg::POS_W-1:0]        rsp_out_col,
   output logic signed [SAMPLE_BITS-1:0]       rsp_pooled,
   output logic                                rsp_run_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pool2d_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pool2d_pkg::CSR_DAT_W-1:0]    csr_wdata
);
   import pool2d_pkg::*;

   localparam int DEPTH  = MAX_KERNEL * MAX_WIDTH;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SLOT_W = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int CNT_W  = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
   localparam int SUM_W  = SAMPLE_BITS + CNT_W;
   localparam int ACNT_W = $clog2(SUM_W + 1);
   localparam int WLIM   = (MAX_WIDTH < POS_LIMIT) ? MAX_WIDTH : POS_LIMIT;
   localparam int DIV_STEPS = SIZE_W;

   typedef enum logic [3:0] {
      S_IDLE, S_DIV, S_COUNT, S_SETUP, S_READ, S_DRAIN, S_CALC, S_AVG, S_OUT
   } state_type;

   state_type state_ff, state_in;

   // Registers.
   logic              mode_ff, mode_in;
   logic [SIZE_W-1:0] in_h_ff, in_h_in, in_w_ff, in_w_in;
   logic [SIZE_W-1:0] out_h_ff, out_h_in, out_w_ff, out_w_in;
   logic [7:0]        win_ff, win_in, stride_ff, stride_in, pad_ff, pad_in;

   // Stream position.
   logic [POS_W-1:0]  row_ff, row_in, col_ff, col_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   // Current sample.
   logic [POS_W-1:0]  cur_r_ff, cur_r_in, cur_c_ff, cur_c_in;
   logic [SLOT_W-1:0] cur_slot_ff, cur_slot_in;

   // Window search per axis.
   logic signed [12:0] bnd_r_ff, bnd_r_in, bnd_c_ff, bnd_c_in;
   logic [SIZE_W-1:0]  lp_r_ff, lp_r_in, lp_c_ff, lp_c_in;
   logic [SIZE_W-1:0]  num_r_ff, num_r_in, num_c_ff, num_c_in;
   logic [SIZE_W-1:0]  q_r_ff, q_r_in, q_c_ff, q_c_in;
   logic [4:0]         rem_r_ff, rem_r_in, rem_c_ff, rem_c_in;
   logic [3:0]         dcnt_ff, dcnt_in;
   logic [SIZE_W-1:0]  o_r_ff, o_r_in, o_c_ff, o_c_in;
   logic [11:0]        p_r_ff, p_r_in, p_c_ff, p_c_in;
   logic [11:0]        p_r0_ff, p_r0_in, p_c0_ff, p_c0_in;
   logic [3:0]         n_r_ff, n_r_in, n_c_ff, n_c_in;
   logic               run_r_ff, run_r_in, run_c_ff, run_c_in;

   // Window walk.
   logic [3:0]         a_ff, a_in, b_ff, b_in;
   logic [SIZE_W-1:0]  row_o_ff, row_o_in, col_o_ff, col_o_in;
   logic [11:0]        row_p_ff, row_p_in, col_p_ff, col_p_in;
   logic [POS_W-1:0]   h_ff, h_in, w_ff, w_in, wlo_ff, wlo_in;
   logic [SLOT_W-1:0]  hslot_ff, hslot_in;
   logic               rd_vld_ff, rd_vld_in;

   // Accumulation and average.
   logic signed [SAMPLE_BITS-1:0] best_ff, best_in;
   logic signed [SUM_W-1:0]       sum_ff, sum_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [SUM_W-1:0]              mag_ff, mag_in;
   logic [CNT_W-1:0]              arem_ff, arem_in;
   logic                          neg_ff, neg_in;
   logic [ACNT_W-1:0]             acnt_ff, acnt_in;

   // Output register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]              rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic signed [SAMPLE_BITS-1:0] rsp_pooled_ff, rsp_pooled_in;
   logic                          rsp_last_ff, rsp_last_in;

   // Effective configuration.
   logic [SIZE_W-1:0] eff_h, eff_w, eff_oh, eff_ow;
   logic [3:0]        kh, kw, sh, sw, pt, pl;

   // Line store ports.
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [SAMPLE_BITS-1:0] rd_data;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input int hi);
      logic [SIZE_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (v > SIZE_W'(hi)) begin
         r = SIZE_W'(hi);
      end
      return r;
   endfunction

   function automatic logic [3:0] clamp_kernel(input logic [3:0] v);
      logic [3:0] r;
      r = v;
      if (v == 4'd0) begin
         r = 4'd1;
      end else if (v > 4'(MAX_KERNEL)) begin
         r = 4'(MAX_KERNEL);
      end
      return r;
   endfunction

   always_comb begin
      eff_h  = clamp_size(in_h_ff, POS_LIMIT);
      eff_w  = clamp_size(in_w_ff, WLIM);
      eff_oh = clamp_size(out_h_ff, POS_LIMIT);
      eff_ow = clamp_size(out_w_ff, POS_LIMIT);
      kh     = clamp_kernel(win_ff[7:4]);
      kw     = clamp_kernel(win_ff[3:0]);
      sh     = (stride_ff[7:4] == 4'd0) ? 4'd1 : stride_ff[7:4];
      sw     = (stride_ff[3:0] == 4'd0) ? 4'd1 : stride_ff[3:0];
      pt     = pad_ff[7:4];
      pl     = pad_ff[3:0];
   end

   pool2d_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_sample),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready    = (state_ff == S_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_row  = rsp_row_ff;
   assign rsp_out_col  = rsp_col_ff;
   assign rsp_pooled   = rsp_pooled_ff;
   assign rsp_run_last = rsp_last_ff;

   always_comb begin
      logic [POS_W-1:0]   r_e, c_e;
      logic [SLOT_W-1:0]  s_e;
      logic signed [12:0] l_r, l_c;
      logic [5:0]         rs_r, rs_c;
      logic               qb_r, qb_c;
      logic               hit_r, hit_c;
      logic [POS_W-1:0]   rlo, clo;
      logic [SLOT_W:0]    row_back, tslot;
      logic signed [SAMPLE_BITS-1:0] v;
      logic [CNT_W:0]     ars;
      logic               aqb;
      logic [SUM_W-1:0]   qsig;
      logic               load;

      state_in = state_ff;
      mode_in = mode_ff; in_h_in = in_h_ff; in_w_in = in_w_ff;
      out_h_in = out_h_ff; out_w_in = out_w_ff;
      win_in = win_ff; stride_in = stride_ff; pad_in = pad_ff;
      row_in = row_ff; col_in = col_ff; slot_in = slot_ff;
      cur_r_in = cur_r_ff; cur_c_in = cur_c_ff; cur_slot_in = cur_slot_ff;
      bnd_r_in = bnd_r_ff; bnd_c_in = bnd_c_ff;
      lp_r_in = lp_r_ff; lp_c_in = lp_c_ff;
      num_r_in = num_r_ff; num_c_in = num_c_ff;
      q_r_in = q_r_ff; q_c_in = q_c_ff;
      rem_r_in = rem_r_ff; rem_c_in = rem_c_ff;
      dcnt_in = dcnt_ff;
      o_r_in = o_r_ff; o_c_in = o_c_ff;
      p_r_in = p_r_ff; p_c_in = p_c_ff;
      p_r0_in = p_r0_ff; p_c0_in = p_c0_ff;
      n_r_in = n_r_ff; n_c_in = n_c_ff;
      run_r_in = run_r_ff; run_c_in = run_c_ff;
      a_in = a_ff; b_in = b_ff;
      row_o_in = row_o_ff; col_o_in = col_o_ff;
      row_p_in = row_p_ff; col_p_in = col_p_ff;
      h_in = h_ff; w_in = w_ff; wlo_in = wlo_ff; hslot_in = hslot_ff;
      best_in = best_ff; sum_in = sum_ff; cnt_in = cnt_ff;
      mag_in = mag_ff; arem_in = arem_ff; neg_in = neg_ff; acnt_in = acnt_ff;
      rsp_row_in = rsp_row_ff; rsp_col_in = rsp_col_ff;
      rsp_pooled_in = rsp_pooled_ff; rsp_last_in = rsp_last_ff;
      rd_vld_in = 1'b0;

      r_e = (SIZE_W'(row_ff) >= eff_h) ? '0 : row_ff;
      c_e = (SIZE_W'(col_ff) >= eff_w) ? '0 : col_ff;
      s_e = (SIZE_W'(row_ff) >= eff_h) ? '0 : slot_ff;
      l_r = $signed({3'b0, r_e}) + 13'sd1 + $signed({9'b0, pt}) - $signed({9'b0, kh});
      l_c = $signed({3'b0, c_e}) + 13'sd1 + $signed({9'b0, pl}) - $signed({9'b0, kw});

      wr_en   = 1'b0;
      wr_addr = ADDR_W'(int'(s_e) * MAX_WIDTH + int'(c_e));
      rd_en   = (state_ff == S_READ);
      rd_addr = ADDR_W'(int'(hslot_ff) * MAX_WIDTH + int'(w_ff));

      rs_r = {rem_r_ff, num_r_ff[SIZE_W-1]};
      rs_c = {rem_c_ff, num_c_ff[SIZE_W-1]};
      qb_r = (rs_r >= {2'b0, sh});
      qb_c = (rs_c >= {2'b0, sw});
      hit_r = (o_r_ff < eff_oh) && ($signed({1'b0, p_r_ff}) <= bnd_r_ff);
      hit_c = (o_c_ff < eff_ow) && ($signed({1'b0, p_c_ff}) <= bnd_c_ff);

      rlo  = (row_p_ff < 12'(pt)) ? '0 : POS_W'(row_p_ff - 12'(pt));
      clo  = (col_p_ff < 12'(pl)) ? '0 : POS_W'(col_p_ff - 12'(pl));
      row_back = (SLOT_W + 1)'(cur_r_ff - rlo);
      tslot = {1'b0, cur_slot_ff} + (SLOT_W + 1)'(MAX_KERNEL) - row_back;
      if (tslot >= (SLOT_W + 1)'(MAX_KERNEL)) begin
         tslot = tslot - (SLOT_W + 1)'(MAX_KERNEL);
      end

      v = $signed(rd_data);
      ars = {arem_ff, mag_ff[SUM_W-1]};
      aqb = (ars >= {1'b0, cnt_ff});
      qsig = neg_ff ? (~mag_ff + SUM_W'(1)) : mag_ff;
      load = 1'b0;

      // Samples read back from the line store are folded in the cycle after their read.
      if (rd_vld_ff) begin
         best_in = (cnt_ff == '0 || v > best_ff) ? v : best_ff;
         sum_in  = sum_ff + SUM_W'(v);
         cnt_in  = cnt_ff + CNT_W'(1);
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      if (csr_valid) begin
         case (csr_index)
            CSR_MODE:        mode_in   = csr_wdata[0];
            CSR_IN_HEIGHT:   in_h_in   = csr_wdata;
            CSR_IN_WIDTH:    in_w_in   = csr_wdata;
            CSR_OUT_HEIGHT:  out_h_in  = csr_wdata;
            CSR_OUT_WIDTH:   out_w_in  = csr_wdata;
            CSR_WINDOW_SIZE: win_in    = csr_wdata[7:0];
            CSR_STRIDE_PAIR: stride_in = csr_wdata[7:0];
            CSR_PAD_PAIR:    pad_in    = csr_wdata[7:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               wr_en       = 1'b1;
               cur_r_in    = r_e;
               cur_c_in    = c_e;
               cur_slot_in = s_e;
               if (SIZE_W'(c_e) + SIZE_W'(1) >= eff_w) begin
                  col_in = '0;
                  if (SIZE_W'(r_e) + SIZE_W'(1) >= eff_h) begin
                     row_in  = '0;
                     slot_in = '0;
                  end else begin
                     row_in  = r_e + POS_W'(1);
                     slot_in = (s_e == SLOT_W'(MAX_KERNEL - 1)) ? '0 : s_e + SLOT_W'(1);
                  end
               end else begin
                  col_in = c_e + POS_W'(1);
               end
               // Only the last row or column closes windows that run past the edge.
               bnd_r_in = (SIZE_W'(r_e) + SIZE_W'(1) == eff_h) ?
                          $signed({3'b0, r_e}) + $signed({9'b0, pt}) : l_r;
               bnd_c_in = (SIZE_W'(c_e) + SIZE_W'(1) == eff_w) ?
                          $signed({3'b0, c_e}) + $signed({9'b0, pl}) : l_c;
               lp_r_in  = l_r[12] ? '0 : l_r[SIZE_W-1:0];
               lp_c_in  = l_c[12] ? '0 : l_c[SIZE_W-1:0];
               num_r_in = (l_r[12] ? '0 : l_r[SIZE_W-1:0]) + SIZE_W'(sh) - SIZE_W'(1);
               num_c_in = (l_c[12] ? '0 : l_c[SIZE_W-1:0]) + SIZE_W'(sw) - SIZE_W'(1);
               q_r_in   = '0;
               q_c_in   = '0;
               rem_r_in = '0;
               rem_c_in = '0;
               dcnt_in  = '0;
               state_in = S_DIV;
            end
         end

         S_DIV: begin
            rem_r_in = qb_r ? 5'(rs_r - {2'b0, sh}) : rs_r[4:0];
            rem_c_in = qb_c ? 5'(rs_c - {2'b0, sw}) : rs_c[4:0];
            q_r_in   = {q_r_ff[SIZE_W-2:0], qb_r};
            q_c_in   = {q_c_ff[SIZE_W-2:0], qb_c};
            num_r_in = {num_r_ff[SIZE_W-2:0], 1'b0};
            num_c_in = {num_c_ff[SIZE_W-2:0], 1'b0};
            dcnt_in  = dcnt_ff + 4'd1;
            if (dcnt_ff == 4'(DIV_STEPS - 1)) begin
               o_r_in   = {q_r_ff[SIZE_W-2:0], qb_r};
               o_c_in   = {q_c_ff[SIZE_W-2:0], qb_c};
               p_r_in   = 12'(lp_r_ff) + 12'(sh) - 12'd1 -
                          12'(qb_r ? 5'(rs_r - {2'b0, sh}) : rs_r[4:0]);
               p_c_in   = 12'(lp_c_ff) + 12'(sw) - 12'd1 -
                          12'(qb_c ? 5'(rs_c - {2'b0, sw}) : rs_c[4:0]);
               p_r0_in  = p_r_in;
               p_c0_in  = p_c_in;
               n_r_in   = '0;
               n_c_in   = '0;
               run_r_in = 1'b1;
               run_c_in = 1'b1;
               state_in = S_COUNT;
            end
         end

         S_COUNT: begin
            if (!run_r_ff && !run_c_ff) begin
               if (n_r_ff == '0 || n_c_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  a_in     = '0;
                  b_in     = '0;
                  row_o_in = q_r_ff;
                  row_p_in = p_r0_ff;
                  col_o_in = q_c_ff;
                  col_p_in = p_c0_ff;
                  state_in = S_SETUP;
               end
            end else begin
               if (run_r_ff) begin
                  if (hit_r) begin
                     n_r_in = n_r_ff + 4'd1;
                     o_r_in = o_r_ff + SIZE_W'(1);
                     p_r_in = p_r_ff + 12'(sh);
                  end else begin
                     run_r_in = 1'b0;
                  end
               end
               if (run_c_ff) begin
                  if (hit_c) begin
                     n_c_in = n_c_ff + 4'd1;
                     o_c_in = o_c_ff + SIZE_W'(1);
                     p_c_in = p_c_ff + 12'(sw);
                  end else begin
                     run_c_in = 1'b0;
                  end
               end
            end
         end

         S_SETUP: begin
            h_in     = rlo;
            hslot_in = tslot[SLOT_W-1:0];
            w_in     = clo;
            wlo_in   = clo;
            cnt_in   = '0;
            sum_in   = '0;
            best_in  = '0;
            state_in = S_READ;
         end

         S_READ: begin
            rd_vld_in = 1'b1;
            if (w_ff == cur_c_ff) begin
               w_in = wlo_ff;
               if (h_ff == cur_r_ff) begin
                  state_in = S_DRAIN;
               end else begin
                  h_in     = h_ff + POS_W'(1);
                  hslot_in = (hslot_ff == SLOT_W'(MAX_KERNEL - 1)) ?
                             '0 : hslot_ff + SLOT_W'(1);
               end
            end else begin
               w_in = w_ff + POS_W'(1);
            end
         end

         S_DRAIN: begin
            state_in = S_CALC;
         end

         S_CALC: begin
            if (mode_ff == MODE_AVG) begin
               neg_in   = sum_ff[SUM_W-1];
               mag_in   = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
               arem_in  = '0;
               acnt_in  = '0;
               state_in = S_AVG;
            end else begin
               state_in = S_OUT;
            end
         end

         S_AVG: begin
            arem_in = aqb ? CNT_W'(ars - {1'b0, cnt_ff}) : ars[CNT_W-1:0];
            mag_in  = {mag_ff[SUM_W-2:0], aqb};
            acnt_in = acnt_ff + ACNT_W'(1);
            if (acnt_ff == ACNT_W'(SUM_W - 1)) begin
               state_in = S_OUT;
            end
         end

         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load          = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_row_in    = row_o_ff[POS_W-1:0];
               rsp_col_in    = col_o_ff[POS_W-1:0];
               rsp_pooled_in = (mode_ff == MODE_AVG) ? qsig[SAMPLE_BITS-1:0] : best_ff;
               rsp_last_in   = (a_ff == n_r_ff - 4'd1) && (b_ff == n_c_ff - 4'd1);
               if (b_ff + 4'd1 < n_c_ff) begin
                  b_in     = b_ff + 4'd1;
                  col_o_in = col_o_ff + SIZE_W'(1);
                  col_p_in = col_p_ff + 12'(sw);
                  state_in = S_SETUP;
               end else if (a_ff + 4'd1 < n_r_ff) begin
                  a_in     = a_ff + 4'd1;
                  b_in     = '0;
                  row_o_in = row_o_ff + SIZE_W'(1);
                  row_p_in = row_p_ff + 12'(sh);
                  col_o_in = q_c_ff;
                  col_p_in = p_c0_ff;
                  state_in = S_SETUP;
               end else begin
                  state_in = S_IDLE;
               end
            end
            if (load) begin
               rsp_valid_in = 1'b1;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cur_r_ff <= cur_r_in; cur_c_ff <= cur_c_in; cur_slot_ff <= cur_slot_in;
      bnd_r_ff <= bnd_r_in; bnd_c_ff <= bnd_c_in;
      lp_r_ff <= lp_r_in; lp_c_ff <= lp_c_in;
      num_r_ff <= num_r_in; num_c_ff <= num_c_in;
      q_r_ff <= q_r_in; q_c_ff <= q_c_in;
      rem_r_ff <= rem_r_in; rem_c_ff <= rem_c_in;
      dcnt_ff <= dcnt_in;
      o_r_ff <= o_r_in; o_c_ff <= o_c_in;
      p_r_ff <= p_r_in; p_c_ff <= p_c_in;
      p_r0_ff <= p_r0_in; p_c0_ff <= p_c0_in;
      n_r_ff <= n_r_in; n_c_ff <= n_c_in;
      run_r_ff <= run_r_in; run_c_ff <= run_c_in;
      a_ff <= a_in; b_ff <= b_in;
      row_o_ff <= row_o_in; col_o_ff <= col_o_in;
      row_p_ff <= row_p_in; col_p_ff <= col_p_in;
      h_ff <= h_in; w_ff <= w_in; wlo_ff <= wlo_in; hslot_ff <= hslot_in;
      best_ff <= best_in; sum_ff <= sum_in; cnt_ff <= cnt_in;
      mag_ff <= mag_in; arem_ff <= arem_in; neg_ff <= neg_in; acnt_ff <= acnt_in;
      rsp_row_ff <= rsp_row_in; rsp_col_ff <= rsp_col_in;
      rsp_pooled_ff <= rsp_pooled_in; rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= 1'b0;
         in_h_ff      <= SIZE_W'(1);
         in_w_ff      <= SIZE_W'(1);
         out_h_ff     <= SIZE_W'(1);
         out_w_ff     <= SIZE_W'(1);
         win_ff       <= 8'h11;
         stride_ff    <= 8'h11;
         pad_ff       <= 8'h00;
         row_ff       <= '0;
         col_ff       <= '0;
         slot_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         in_h_ff      <= in_h_in;
         in_w_ff      <= in_w_in;
         out_h_ff     <= out_h_in;
         out_w_ff     <= out_w_in;
         win_ff       <= win_in;
         stride_ff    <= stride_in;
         pad_ff       <= pad_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         slot_ff      <= slot_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[sv/pool2d_chk.sv]
`timescale 1ns / 1ps
module pool2d_chk #(
   parameter int SAMPLE_BITS = 16
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [pool2d_pkg::POS_W-1:0]      rsp_out_row,
   input logic [pool2d_pkg::POS_W-1:0]      rsp_out_col,
   input logic signed [SAMPLE_BITS-1:0]     rsp_pooled,
   input logic                              rsp_run_last
);
   import pool2d_pkg::*;

   // After reset the block is empty and ready for the first word.
   a_reset_state: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("block not empty after reset");

   // A word that is not taken holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pooled) &&
         $stable(rsp_out_row) && $stable(rsp_out_col) && $stable(rsp_run_last)))
      else $error("result word changed while stalled");

   // Accepting a sample makes the block busy and drops req_ready.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("sample accepted while the previous one is still in work");

endmodule

bind pool2d_max_avg_stream_top pool2d_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_pool2d_chk (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_row  (rsp_out_row),
   .rsp_out_col  (rsp_out_col),
   .rsp_pooled   (rsp_pooled),
   .rsp_run_last (rsp_run_last)
);
